// ===== src/pvd_pkg.sv =====
// Package for the prefix varint decoder: token kinds, lead-byte masks,
// decoder state and token record types. No dependencies.
package pvd_pkg;

  typedef enum logic [1:0] {
    KIND_NUMBER = 2'd0,
    KIND_FLAG1  = 2'd1,
    KIND_FLAG2  = 2'd2,
    KIND_EOS    = 2'd3
  } token_kind_t;

  // lead byte classification
  localparam logic [7:0] LEAD_TOP_MASK  = 8'h80;
  localparam logic [7:0] LEAD_MASK2     = 8'hC0;
  localparam logic [7:0] LEAD_PFX2      = 8'h80;
  localparam logic [7:0] LEAD_MASK4     = 8'hF0;
  localparam logic [7:0] LEAD_PFX3      = 8'hC0;
  localparam logic [7:0] LEAD_PFX4      = 8'hD0;
  localparam logic [7:0] LEAD_PFX5      = 8'hE0;
  localparam logic [7:0] LEAD_MASK5     = 8'hF8;
  localparam logic [7:0] LEAD_FLAG1     = 8'hF0;
  localparam logic [7:0] LEAD_FLAG2     = 8'hF8;
  localparam logic [7:0] LEAD_EOS       = 8'hFF;
  localparam logic [7:0] PAYLOAD_MASK2  = 8'h3F;
  localparam logic [7:0] PAYLOAD_MASK4  = 8'h0F;
  localparam logic [7:0] FLAG_IDX_MASK  = 8'h07;

  localparam int unsigned NUM_W   = 32;
  localparam int unsigned COUNT_W = 3;

  typedef struct packed {
    logic [7:0]         lead_byte;
    logic [COUNT_W-1:0] bytes_left;
    logic [NUM_W-1:0]   partial_sum;
    logic [COUNT_W-1:0] bytes_seen;
  } dec_state_t;

  typedef struct packed {
    token_kind_t        token_kind;
    logic [NUM_W-1:0]   number_value;
    logic [2:0]         flag_index;
    logic [7:0]         flag_value;
    logic [COUNT_W-1:0] token_bytes;
  } token_t;

endpackage

// ===== src/pvd_ifs.sv =====
// Valid/ready stream interfaces for the prefix varint decoder:
// the byte input channel and the token output channel. No dependencies.
interface pvd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;

  modport source (output valid, output in_byte, input ready);
  modport sink   (input valid, input in_byte, output ready);
endinterface

interface pvd_token_if;
  logic        valid;
  logic        ready;
  logic [1:0]  token_kind;
  logic [31:0] number_value;
  logic [2:0]  flag_index;
  logic [7:0]  flag_value;
  logic [2:0]  token_bytes;

  modport source (output valid, output token_kind, output number_value,
                  output flag_index, output flag_value, output token_bytes,
                  input ready);
  modport sink   (input valid, input token_kind, input number_value,
                  input flag_index, input flag_value, input token_bytes,
                  output ready);
endinterface

// ===== src/pvd_in_stage.sv =====
// Input register stage of the prefix varint decoder.
// Uses pvd_byte_if.
module pvd_in_stage (
  input  logic       clk,
  input  logic       rst,
  pvd_byte_if.sink   in_ch,
  input  logic       advance,
  output logic       held_valid,
  output logic [7:0] held_byte
);

  assign in_ch.ready = !held_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      held_valid <= 1'b0;
    end else if (in_ch.ready) begin
      held_valid <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ch.valid && in_ch.ready) begin
      held_byte <= in_ch.in_byte;
    end
  end

endmodule

// ===== src/pvd_decode.sv =====
// Token decode logic and decoder state registers.
// Depends on pvd_pkg.
module pvd_decode
  import pvd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  logic [7:0] in_byte,
  output logic       emit,
  output token_t     token
);

  dec_state_t st;
  dec_state_t st_next;
  logic [NUM_W-1:0] shifted_sum;

  assign shifted_sum = {st.partial_sum[NUM_W-8:0], 7'b0} | {{(NUM_W-8){1'b0}}, in_byte};

  always_comb begin
    st_next = st;
    emit    = 1'b0;
    token   = '{token_kind: KIND_NUMBER, number_value: '0, flag_index: '0,
                flag_value: '0, token_bytes: '0};

    if (st.bytes_left == '0) begin
      st_next.lead_byte   = in_byte;
      st_next.bytes_seen  = COUNT_W'(1);
      st_next.partial_sum = '0;
      token.token_bytes   = COUNT_W'(1);
      if ((in_byte & LEAD_TOP_MASK) == 8'h00) begin
        emit               = 1'b1;
        token.number_value = {{(NUM_W-8){1'b0}}, in_byte};
      end else if ((in_byte & LEAD_MASK2) == LEAD_PFX2) begin
        st_next.partial_sum = {{(NUM_W-8){1'b0}}, in_byte & PAYLOAD_MASK2};
        st_next.bytes_left  = COUNT_W'(1);
      end else if ((in_byte & LEAD_MASK4) == LEAD_PFX3) begin
        st_next.partial_sum = {{(NUM_W-8){1'b0}}, in_byte & PAYLOAD_MASK4};
        st_next.bytes_left  = COUNT_W'(2);
      end else if ((in_byte & LEAD_MASK4) == LEAD_PFX4) begin
        st_next.partial_sum = {{(NUM_W-8){1'b0}}, in_byte & PAYLOAD_MASK4};
        st_next.bytes_left  = COUNT_W'(3);
      end else if ((in_byte & LEAD_MASK4) == LEAD_PFX5) begin
        st_next.partial_sum = {{(NUM_W-8){1'b0}}, in_byte & PAYLOAD_MASK4};
        st_next.bytes_left  = COUNT_W'(4);
      end else if ((in_byte & LEAD_MASK5) == LEAD_FLAG1) begin
        emit             = 1'b1;
        token.token_kind = KIND_FLAG1;
        token.flag_index = in_byte[2:0];
      end else if (in_byte != LEAD_EOS) begin
        st_next.bytes_left = COUNT_W'(1);
      end else begin
        emit             = 1'b1;
        token.token_kind = KIND_EOS;
      end
    end else begin
      st_next.bytes_seen = st.bytes_seen + COUNT_W'(1);
      st_next.bytes_left = st.bytes_left - COUNT_W'(1);
      token.token_bytes  = st_next.bytes_seen;
      if ((st.lead_byte & LEAD_MASK5) == LEAD_FLAG2) begin
        st_next.bytes_left = '0;
        emit               = 1'b1;
        token.token_kind   = KIND_FLAG2;
        token.flag_index   = st.lead_byte[2:0];
        token.flag_value   = in_byte;
      end else begin
        st_next.partial_sum = shifted_sum;
        if (st_next.bytes_left == '0) begin
          emit               = 1'b1;
          token.number_value = shifted_sum;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '0;
    end else if (step) begin
      st <= st_next;
    end
  end

endmodule

// ===== src/pvd_out_stage.sv =====
// Result register stage of the prefix varint decoder.
// Depends on pvd_pkg and pvd_token_if.
module pvd_out_stage
  import pvd_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        load,
  input  token_t      token,
  output logic        can_load,
  pvd_token_if.source out_ch
);

  token_t held;

  assign can_load = !out_ch.valid || out_ch.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_ch.valid <= 1'b0;
    end else if (can_load) begin
      out_ch.valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load && can_load) begin
      held <= token;
    end
  end

  assign out_ch.token_kind   = held.token_kind;
  assign out_ch.number_value = held.number_value;
  assign out_ch.flag_index   = held.flag_index;
  assign out_ch.flag_value   = held.flag_value;
  assign out_ch.token_bytes  = held.token_bytes;

endmodule

// ===== src/prefix_varint_decoder.sv =====
// Prefix varint decoder, top level: input register, decode, result register.
// Depends on pvd_pkg, pvd_ifs, pvd_in_stage, pvd_decode, pvd_out_stage.
//
// Parses a byte stream of prefix-coded tokens. Each byte accepted on in_ch
// is first captured in an input register; the decode logic then classifies
// it (as a lead byte or as a continuation of the open token), updates the
// lead byte / remaining count / partial sum / byte count, and, on the last
// byte of a token, loads one transaction into the result register that
// drives out_ch. Bytes that do not close a token produce no transaction.
// Throughput is one byte per cycle as long as out_ch takes tokens; a
// token's last byte passes through the input register and then the result
// register before its output transaction is valid. The decode step only
// advances when the result register is empty or being drained, so
// backpressure on out_ch stalls the input register and then in_ch.ready.
// Number payloads follow the stream format exactly: lead bits masked, then
// sum = (sum << 7) | byte with all 8 continuation bits kept and anything
// above bit 31 dropped. Non-number tokens report zero in number_value;
// flag_index and flag_value are zero where unused.
module prefix_varint_decoder
  import pvd_pkg::*;
(
  input logic         clk,
  input logic         rst,
  pvd_byte_if.sink    in_ch,
  pvd_token_if.source out_ch
);

  logic       held_valid;
  logic [7:0] held_byte;
  logic       can_load;
  logic       advance;
  logic       emit;
  token_t     token;

  // a held byte moves through decode only when its token (if any) has a slot
  assign advance = held_valid && can_load;

  pvd_in_stage u_in (
    .clk        (clk),
    .rst        (rst),
    .in_ch      (in_ch),
    .advance    (advance),
    .held_valid (held_valid),
    .held_byte  (held_byte)
  );

  pvd_decode u_dec (
    .clk     (clk),
    .rst     (rst),
    .step    (advance),
    .in_byte (held_byte),
    .emit    (emit),
    .token   (token)
  );

  pvd_out_stage u_out (
    .clk      (clk),
    .rst      (rst),
    .load     (advance && emit),
    .token    (token),
    .can_load (can_load),
    .out_ch   (out_ch)
  );

endmodule

// ===== src/pvd_checker.sv =====
// Port-level assertions for the prefix varint decoder, bound to the top.
// Depends on pvd_pkg and prefix_varint_decoder.
module pvd_checker
  import pvd_pkg::*;
(
  input logic        clk,
  input logic        rst,
  input logic        out_valid,
  input logic        out_ready,
  input logic [1:0]  token_kind,
  input logic [31:0] number_value,
  input logic [2:0]  token_bytes
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("token dropped while stalled");

  a_zero_num: assert property (@(posedge clk) disable iff (rst)
    out_valid && token_kind != KIND_NUMBER |-> number_value == '0)
    else $error("non-number token carries a number");

  a_len_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> token_bytes >= 3'd1 && token_bytes <= 3'd5)
    else $error("token length out of range");

  a_len_kind: assert property (@(posedge clk) disable iff (rst)
    out_valid && (token_kind == KIND_FLAG1 || token_kind == KIND_EOS)
      |-> token_bytes == 3'd1)
    else $error("one-byte token with wrong length");

  // first edge out of reset: result register must still be empty
  a_reset: assert property (@(posedge clk) !rst && $past(rst) |-> !out_valid)
    else $error("token valid right after reset");

endmodule

bind prefix_varint_decoder pvd_checker u_pvd_checker (
  .clk          (clk),
  .rst          (rst),
  .out_valid    (out_ch.valid),
  .out_ready    (out_ch.ready),
  .token_kind   (out_ch.token_kind),
  .number_value (out_ch.number_value),
  .token_bytes  (out_ch.token_bytes)
);

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for prefix_varint_decoder: byte driver, token monitor,
// and a behavioral token predictor. Depends on pvd_pkg, pvd_ifs and the RTL top.
module tb_top;
  import pvd_pkg::*;

  localparam int HOLD_CYCLES = 300;  // long receiver hold-off, fills the block
  localparam int STALL_LIMIT = 4000; // cycles with no transaction before giving up
  localparam int PHASE_BYTES = 155;  // random bytes queued per idling phase

  logic clk = 1'b0;
  logic rst = 1'b1;

  always #6 clk = ~clk;

  pvd_byte_if  byte_ch ();
  pvd_token_if tok_ch ();

  prefix_varint_decoder uut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (byte_ch),
    .out_ch (tok_ch)
  );

  // Stimulus bytes waiting to be driven, and tokens the decoder must produce.
  logic [7:0] byte_queue [$];
  token_t     expected_tokens [$];

  // Idling knobs, percent of cycles; changed by the stimulus block per phase.
  int send_idle_pct = 0;
  int recv_stall_pct = 0;

  // Receiver hold-off request: bumped by the stimulus block, timed by the monitor.
  int hold_req = 0;
  int hold_seen;
  int hold_left;

  int err_count = 0;
  int bytes_sent = 0;
  int tokens_checked = 0;
  int kind_seen [4] = '{0, 0, 0, 0};
  int quiet_cycles;

  // Predictor state: lead byte of the open token, bytes still due, payload
  // gathered so far and bytes taken so far.
  logic [7:0]  dec_lead = '0;
  logic [2:0]  dec_left = '0;
  logic [31:0] dec_sum  = '0;
  logic [2:0]  dec_seen = '0;

  task report_mismatch(input string what, input logic [31:0] want, input logic [31:0] got);
    err_count++;
    $display("mismatch at token %0d: %s expected 0x%0h got 0x%0h",
             tokens_checked, what, want, got);
  endtask

  // Advance the decoder model by one accepted byte; queue a token if it
  // closes one.
  task automatic advance_decoder(input logic [7:0] b);
    token_t tok;
    logic   done;
    tok = '0;
    tok.token_kind = KIND_NUMBER;
    done = 1'b0;
    if (dec_left == 3'd0) begin
      // lead byte: classify by prefix
      dec_lead = b;
      dec_seen = 3'd1;
      dec_sum = '0;
      tok.token_bytes = 3'd1;
      if ((b & LEAD_TOP_MASK) == 8'h00) begin
        tok.number_value = {24'h0, b};
        done = 1'b1;
      end else if ((b & LEAD_MASK2) == LEAD_PFX2) begin
        dec_sum = {24'h0, b & PAYLOAD_MASK2};
        dec_left = 3'd1;
      end else if ((b & LEAD_MASK4) == LEAD_PFX3) begin
        dec_sum = {24'h0, b & PAYLOAD_MASK4};
        dec_left = 3'd2;
      end else if ((b & LEAD_MASK4) == LEAD_PFX4) begin
        dec_sum = {24'h0, b & PAYLOAD_MASK4};
        dec_left = 3'd3;
      end else if ((b & LEAD_MASK4) == LEAD_PFX5) begin
        dec_sum = {24'h0, b & PAYLOAD_MASK4};
        dec_left = 3'd4;
      end else if ((b & LEAD_MASK5) == LEAD_FLAG1) begin
        tok.token_kind = KIND_FLAG1;
        tok.flag_index = b[2:0];
        done = 1'b1;
      end else if (b != LEAD_EOS) begin
        dec_left = 3'd1;  // flag with value: one value byte follows
      end else begin
        tok.token_kind = KIND_EOS;
        done = 1'b1;
      end
    end else begin
      // continuation: any byte value, even one that looks like a lead
      dec_seen = dec_seen + 3'd1;
      dec_left = dec_left - 3'd1;
      tok.token_bytes = dec_seen;
      if ((dec_lead & LEAD_MASK5) == LEAD_FLAG2) begin
        dec_left = 3'd0;
        tok.token_kind = KIND_FLAG2;
        tok.flag_index = dec_lead[2:0];
        tok.flag_value = b;
        done = 1'b1;
      end else begin
        // all 8 bits kept, overlapping the upper payload; truncate to 32
        dec_sum = {dec_sum[24:0], 7'b0} | {24'h0, b};
        if (dec_left == 3'd0) begin
          tok.number_value = dec_sum;
          done = 1'b1;
        end
      end
    end
    if (done)
      expected_tokens.push_back(tok);
  endtask

  // Byte driver. A byte that is offered stays on the bus until taken; the
  // model advances on the edge where the transaction completes.
  always @(posedge clk) begin : drive_bytes
    logic take;
    if (rst) begin
      byte_ch.valid <= 1'b0;
      byte_ch.in_byte <= '0;
    end else begin
      take = byte_ch.valid && byte_ch.ready;
      if (take) begin
        advance_decoder(byte_ch.in_byte);
        void'(byte_queue.pop_front());
        bytes_sent++;
      end
      if (byte_ch.valid && !take) begin
        // hold the current transaction
      end else if (byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        byte_ch.valid <= 1'b1;
        byte_ch.in_byte <= byte_queue[0];
      end else begin
        byte_ch.valid <= 1'b0;
      end
    end
  end

  // Token monitor and ready generator. Checks every output transaction
  // against the oldest predicted token; runs the hold-off counter.
  always @(posedge clk) begin : watch_tokens
    token_t want;
    if (rst) begin
      tok_ch.ready <= 1'b0;
      hold_seen <= 0;
      hold_left <= 0;
    end else begin
      if (tok_ch.valid && tok_ch.ready) begin
        if (expected_tokens.size() == 0) begin
          report_mismatch("unexpected token, kind", 32'h0, {30'h0, tok_ch.token_kind});
        end else begin
          want = expected_tokens.pop_front();
          kind_seen[want.token_kind]++;
          if (tok_ch.token_kind !== want.token_kind)
            report_mismatch("token_kind", 32'(want.token_kind), 32'(tok_ch.token_kind));
          if (tok_ch.number_value !== want.number_value)
            report_mismatch("number_value", want.number_value, tok_ch.number_value);
          if (tok_ch.flag_index !== want.flag_index)
            report_mismatch("flag_index", 32'(want.flag_index), 32'(tok_ch.flag_index));
          if (tok_ch.flag_value !== want.flag_value)
            report_mismatch("flag_value", 32'(want.flag_value), 32'(tok_ch.flag_value));
          if (tok_ch.token_bytes !== want.token_bytes)
            report_mismatch("token_bytes", 32'(want.token_bytes), 32'(tok_ch.token_bytes));
        end
        tokens_checked++;
      end
      if (hold_seen != hold_req) begin
        hold_seen <= hold_req;
        hold_left <= HOLD_CYCLES;
        tok_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
        tok_ch.ready <= 1'b0;
      end else begin
        tok_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  // Watchdog: any stretch with no transaction on either channel that runs
  // past the limit means the block hung.
  always @(posedge clk) begin
    if (rst || (byte_ch.valid && byte_ch.ready) || (tok_ch.valid && tok_ch.ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("timeout: %0d bytes still queued, %0d tokens outstanding",
                 byte_queue.size(), expected_tokens.size());
        $display("[prefix_varint_decoder] ERROR");
        $finish;
      end
    end
  end

  // Continuation byte: uniform half the time, else one with the top bit set (looks like a lead) or 0xFF.
  function automatic logic [7:0] cont_byte();
    case ($urandom_range(3))
      0:       return 8'h80 | 8'($urandom_range(127));
      1:       return LEAD_EOS;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // Queue one well-formed token with random content, or a raw noise byte.
  task automatic queue_random_token();
    int sel;
    int n;
    logic [7:0] lead;
    sel = $urandom_range(19);
    n = 0;
    case (sel)
      0, 1:    lead = 8'($urandom_range(127));
      2, 3, 4: begin lead = LEAD_PFX2 | 8'($urandom_range(63)); n = 1; end
      5, 6:    begin lead = LEAD_PFX3 | 8'($urandom_range(15)); n = 2; end
      7, 8:    begin lead = LEAD_PFX4 | 8'($urandom_range(15)); n = 3; end
      9, 10,
      11:      begin lead = LEAD_PFX5 | 8'($urandom_range(15)); n = 4; end
      12, 13:  lead = LEAD_FLAG1 | 8'($urandom_range(7));
      14, 15:  begin lead = LEAD_FLAG2 | 8'($urandom_range(6)); n = 1; end
      16:      lead = LEAD_EOS;
      default: lead = 8'($urandom_range(255));  // noise, may open or cut a token
    endcase
    byte_queue.push_back(lead);
    repeat (n) byte_queue.push_back(cont_byte());
  endtask

  initial begin : stimulus
    int send_tbl [4] = '{0, 69, 0, 31};
    int recv_tbl [4] = '{0, 0, 69, 31};
    int start_cnt;
    byte_ch.valid = 1'b0;
    byte_ch.in_byte = '0;
    tok_ch.ready = 1'b0;

    // Directed: one- and two-byte number extremes, three- and four-byte numbers,
    // 5-byte overflow, flag indexes 0 and 7, flag-with-value, end of stream,
    // and continuation bytes that look like leads.
    byte_queue = {8'h00, 8'h7F,
                  8'h80, 8'h00,
                  8'hBF, 8'hFF,
                  8'hC5, 8'h80, 8'h7F,
                  8'hD0, 8'hFF, 8'h00, 8'h01,
                  8'hEF, 8'hFF, 8'hFF, 8'hFF, 8'hFF,
                  8'hF0, 8'hF7, 8'hFF,
                  8'hFE, 8'hF0,
                  8'hF8, 8'h00};

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    while (byte_queue.size() != 0 || expected_tokens.size() != 0)
      @(posedge clk);

    // Random phases, one per idling mix. The first one opens with a long
    // receiver hold-off so the input side backs up and stalls.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = send_tbl[ph];
      recv_stall_pct = recv_tbl[ph];
      if (ph == 0)
        hold_req++;
      start_cnt = byte_queue.size();
      while (byte_queue.size() - start_cnt < PHASE_BYTES)
        queue_random_token();
      while (byte_queue.size() != 0 || expected_tokens.size() != 0)
        @(posedge clk);
    end

    // Let any token still in the pipeline show up before finishing.
    repeat (10) @(posedge clk);

    $display("covered %0d bytes, %0d tokens: %0d numbers, %0d flags, %0d valued flags, %0d eos",
             bytes_sent, tokens_checked, kind_seen[KIND_NUMBER], kind_seen[KIND_FLAG1],
             kind_seen[KIND_FLAG2], kind_seen[KIND_EOS]);
    $display("idle mixes: none, sender 69%%, receiver 69%%, both 31%%; one %0d-cycle hold-off",
             HOLD_CYCLES);
    if (err_count == 0) begin
      $display("[prefix_varint_decoder] OK");
    end else begin
      $display("[prefix_varint_decoder] ERROR");
    end
    $finish;
  end

endmodule

// ===== files.f =====
src/pvd_pkg.sv
src/pvd_ifs.sv
src/pvd_in_stage.sv
src/pvd_decode.sv
src/pvd_out_stage.sv
src/prefix_varint_decoder.sv
src/pvd_checker.sv
tb/tb_top.sv
